@@ sv/bcr_pkg.sv @@
// bcr_pkg: shared types and constants for the circle rasterizer
// no dependencies; imported by bcr_step, bcr_emit and the top level
package bcr_pkg;

	// request command codes
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	// midpoint decision constants
	localparam int C_DEC_INIT   = 3;
	localparam int C_RAD_SHIFT  = 1;  // 2*r
	localparam int C_STEP_SHIFT = 2;  // 4*(...)
	localparam int C_INC_DIAG   = 10;
	localparam int C_INC_AXIS   = 6;

	// symmetric point index: bit0 negates first offset, bit1 the second, bit2 swaps x/y
	localparam int PT_IDX_W = 3;
	localparam logic [PT_IDX_W-1:0] PT_FIRST_FULL  = 3'd0;
	localparam logic [PT_IDX_W-1:0] PT_LAST_FULL   = 3'd7;
	localparam logic [PT_IDX_W-1:0] PT_FIRST_LOWER = 3'd2;
	localparam logic [PT_IDX_W-1:0] PT_LAST_LOWER  = 3'd3;

	// control from the step unit to the point emitter
	typedef struct packed {
		logic load;   // a new point burst is handed over
		logic lower;  // emit only the two lower points
		logic done;   // this iteration ends the circle
	} bcr_ctl_t;

endpackage

@@ sv/bcr_cmd_if.sv @@
// bcr_cmd_if: valid/ready channel carrying one circle command request
// no dependencies
interface bcr_cmd_if #(
	parameter int COORD_BITS  = 12,
	parameter int RADIUS_BITS = 10
);
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic signed [COORD_BITS-1:0]  center_x;
	logic signed [COORD_BITS-1:0]  center_y;
	logic        [RADIUS_BITS-1:0] radius;
	logic                          lower_arc_only;

	modport source (
		output valid, command, center_x, center_y, radius, lower_arc_only,
		input  ready
	);
	modport sink (
		input  valid, command, center_x, center_y, radius, lower_arc_only,
		output ready
	);
endinterface

@@ sv/bcr_pix_if.sv @@
// bcr_pix_if: valid/ready channel carrying one plotted point request
// no dependencies
interface bcr_pix_if #(
	parameter int COORD_BITS = 12
);
	logic                        valid;
	logic                        ready;
	logic signed [COORD_BITS:0]  pixel_x;
	logic signed [COORD_BITS:0]  pixel_y;
	logic                        last;
	logic                        done_res;

	modport source (
		output valid, pixel_x, pixel_y, last, done_res,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, last, done_res,
		output ready
	);
endinterface

@@ sv/bcr_step.sv @@
// bcr_step: circle state registers and one midpoint iteration per accepted step request of an active circle
// depends on bcr_pkg and bcr_cmd_if
module bcr_step #(
	parameter int RADIUS_BITS = 10,
	parameter int COORD_BITS  = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	bcr_cmd_if.sink                       cmd,
	input  logic                          slot_free,
	output bcr_pkg::bcr_ctl_t             ctl,
	output logic signed [COORD_BITS-1:0]  cx,
	output logic signed [COORD_BITS-1:0]  cy,
	output logic signed [RADIUS_BITS:0]   ox,
	output logic signed [RADIUS_BITS:0]   oy
);
	import bcr_pkg::*;

	localparam int OFF_BITS = RADIUS_BITS + 1;
	localparam int DEC_BITS = RADIUS_BITS + 6;

	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	// offsets are signed: a zero radius steps y down to -1 on its overshoot
	logic signed [OFF_BITS-1:0]   ox_q, oy_q;
	logic signed [DEC_BITS-1:0]   dec_q;
	logic                         lower_q;
	logic                         active_q;

	logic                         accept, is_start, gt;
	logic signed [OFF_BITS-1:0]   x_n, y_n;
	logic signed [DEC_BITS-1:0]   xw, yw, rw, inc, dec_step, dec_start;
	logic                         done_n;

	assign cmd.ready = slot_free;
	assign accept    = cmd.valid && slot_free;
	assign is_start  = (cmd.command == CMD_START);

	// one midpoint iteration from the stored offsets
	assign gt       = !dec_q[DEC_BITS-1] && (dec_q != '0);
	assign x_n      = ox_q + OFF_BITS'(1);
	assign y_n      = gt ? (oy_q - OFF_BITS'(1)) : oy_q;
	assign xw       = DEC_BITS'(x_n);
	assign yw       = DEC_BITS'(y_n);
	assign inc      = gt ? (((xw - yw) <<< C_STEP_SHIFT) + DEC_BITS'(C_INC_DIAG))
	                     : ((xw <<< C_STEP_SHIFT) + DEC_BITS'(C_INC_AXIS));
	assign dec_step = dec_q + inc;
	assign done_n   = (y_n < x_n);

	assign rw        = DEC_BITS'(cmd.radius);
	assign dec_start = DEC_BITS'(C_DEC_INIT) - (rw <<< C_RAD_SHIFT);

	// burst handed to the emitter
	always_comb begin
		ctl.load  = accept && (is_start || active_q);
		ctl.lower = !is_start && lower_q;
		ctl.done  = !is_start && done_n;
		cx        = is_start ? cmd.center_x : cx_q;
		cy        = is_start ? cmd.center_y : cy_q;
		ox        = is_start ? '0 : x_n;
		oy        = is_start ? OFF_BITS'(cmd.radius) : y_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
			dec_q    <= '0;
			lower_q  <= 1'b0;
			active_q <= 1'b0;
		end else if (accept) begin
			if (is_start) begin
				cx_q     <= cmd.center_x;
				cy_q     <= cmd.center_y;
				ox_q     <= '0;
				oy_q     <= OFF_BITS'(cmd.radius);
				dec_q    <= dec_start;
				lower_q  <= cmd.lower_arc_only;
				active_q <= 1'b1;
			end else if (active_q) begin
				ox_q     <= x_n;
				oy_q     <= y_n;
				dec_q    <= dec_step;
				active_q <= !done_n;
			end
		end
	end

endmodule

@@ sv/bcr_emit.sv @@
// bcr_emit: sends a held burst's symmetric points one per cycle unless stalled
// depends on bcr_pkg and bcr_pix_if
module bcr_emit #(
	parameter int RADIUS_BITS = 10,
	parameter int COORD_BITS  = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bcr_pkg::bcr_ctl_t             ctl,
	input  logic signed [COORD_BITS-1:0]  cx,
	input  logic signed [COORD_BITS-1:0]  cy,
	input  logic signed [RADIUS_BITS:0]   ox,
	input  logic signed [RADIUS_BITS:0]   oy,
	output logic                          slot_free,
	bcr_pix_if.source                     pix
);
	import bcr_pkg::*;

	localparam int OFF_BITS = RADIUS_BITS + 1;
	localparam int OUT_BITS = COORD_BITS + 1;
	localparam int SUM_W    = ((COORD_BITS > OFF_BITS + 1) ? COORD_BITS : OFF_BITS + 1) + 1;

	logic                         busy_q;
	logic        [PT_IDX_W-1:0]   idx_q;
	logic                         lower_q, done_q;
	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	logic signed [OFF_BITS-1:0]   ox_q, oy_q;

	logic                         ovalid_q, last_q, dn_q;
	logic signed [OUT_BITS-1:0]   px_q, py_q;

	logic                         can_push, push, last_pt;
	logic signed [OFF_BITS-1:0]   a, b;
	logic signed [SUM_W-1:0]      cxw, cyw, aw, bw, px_w, py_w;

	assign can_push  = !ovalid_q || pix.ready;
	assign push      = busy_q && can_push;
	assign last_pt   = (idx_q == (lower_q ? PT_LAST_LOWER : PT_LAST_FULL));
	assign slot_free = !busy_q || (push && last_pt);

	// idx bit2 swaps the offsets, bit0/bit1 negate them
	assign a    = idx_q[2] ? oy_q : ox_q;
	assign b    = idx_q[2] ? ox_q : oy_q;
	assign cxw  = {{(SUM_W-COORD_BITS){cx_q[COORD_BITS-1]}}, cx_q};
	assign cyw  = {{(SUM_W-COORD_BITS){cy_q[COORD_BITS-1]}}, cy_q};
	assign aw   = SUM_W'(a);
	assign bw   = SUM_W'(b);
	assign px_w = idx_q[0] ? (cxw - aw) : (cxw + aw);
	assign py_w = idx_q[1] ? (cyw - bw) : (cyw + bw);

	assign pix.valid    = ovalid_q;
	assign pix.pixel_x  = px_q;
	assign pix.pixel_y  = py_q;
	assign pix.last     = last_q;
	assign pix.done_res = dn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= PT_FIRST_FULL;
			lower_q <= 1'b0;
			done_q  <= 1'b0;
		end else if (ctl.load) begin
			busy_q  <= 1'b1;
			idx_q   <= ctl.lower ? PT_FIRST_LOWER : PT_FIRST_FULL;
			lower_q <= ctl.lower;
			done_q  <= ctl.done;
		end else if (push) begin
			if (last_pt) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + PT_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cx_q <= cx;
			cy_q <= cy;
			ox_q <= ox;
			oy_q <= oy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (push) begin
			ovalid_q <= 1'b1;
		end else if (pix.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			px_q   <= px_w[OUT_BITS-1:0];
			py_q   <= py_w[OUT_BITS-1:0];
			last_q <= last_pt;
			dn_q   <= done_q;
		end
	end

endmodule

@@ sv/bresenham_circle_rasterizer_top.sv @@
// Midpoint circle rasterizer. A start request (command 0) latches centre, radius and the
// lower-arc flag and yields the eight symmetric points of offset (0, radius); each step
// request (command 1) advances x once and yields eight points, or two lower points in
// lower-arc mode; a step with no circle in progress is taken and yields nothing. Points
// leave through an output register, one per cycle while the output is not stalled; last
// marks the final point of a request and done_res marks every point of the iteration that
// ends the circle. The single point emitter takes the next request in the cycle its last
// point moves out.
// depends on bcr_pkg, bcr_cmd_if, bcr_pix_if, bcr_step and bcr_emit
module bresenham_circle_rasterizer_top #(
	parameter int RADIUS_BITS = 10,
	parameter int COORD_BITS  = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	bcr_cmd_if.sink    cmd,
	bcr_pix_if.source  pixel
);
	import bcr_pkg::*;

	bcr_ctl_t                     ctl;
	logic                         slot_free;
	logic signed [COORD_BITS-1:0] cx, cy;
	logic signed [RADIUS_BITS:0]  ox, oy;

	bcr_step #(
		.RADIUS_BITS (RADIUS_BITS),
		.COORD_BITS  (COORD_BITS)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.slot_free (slot_free),
		.ctl       (ctl),
		.cx        (cx),
		.cy        (cy),
		.ox        (ox),
		.oy        (oy)
	);

	bcr_emit #(
		.RADIUS_BITS (RADIUS_BITS),
		.COORD_BITS  (COORD_BITS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cx        (cx),
		.cy        (cy),
		.ox        (ox),
		.oy        (oy),
		.slot_free (slot_free),
		.pix       (pixel)
	);

endmodule
